/* hw/rtl/gcd_pkg.sv */
// Shared types, Q60 constants and elaboration-time table functions for the distance core.
package gcd_pkg;

    typedef logic signed [63:0] t_q60;
    typedef logic signed [33:0] t_turn;

    localparam t_q60 ONE_Q = 64'sh1000_0000_0000_0000;
    localparam t_q60 PI_Q  = 64'sh3243_F6A8_885A_308D;
    localparam t_q60 DEG_Q = PI_Q / 180;

    // atan(1) and the seed of the inverse-gain iteration
    localparam t_q60 ATAN_ONE  = PI_Q / 4;
    localparam t_q60 GAIN_SEED = ONE_Q / 5 * 3;

    // angle units are 2^-23 degree
    localparam t_turn QUARTER_TURN = 34'sd754974720;
    localparam t_turn HALF_TURN    = 34'sd1509949440;
    localparam t_turn FULL_TURN    = 34'sd3019898880;

    localparam int ISQRT_STEPS = 31;

    localparam logic [2:0]  REG_RADIUS_ADDR = 3'd0;
    localparam logic [23:0] RADIUS_RESET    = 24'd6378137;

    // exact signed product, magnitude shifted right and truncated to 63 bits
    function automatic t_q60 mulsh_f(input t_q60 a, input t_q60 b, input int sh);
        logic [127:0] p;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  m;
        logic         neg;
        neg = a[63] ^ b[63];
        ua  = a[63] ? 64'(-a) : 64'(a);
        ub  = b[63] ? 64'(-b) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        m   = 64'(p >> sh);
        m[63] = 1'b0;
        return neg ? t_q60'(-m) : t_q60'(m);
    endfunction

    // restoring long division of non-negative values, for the constant tables only
    function automatic t_q60 udiv_f(input t_q60 num, input int den);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] d;
        q = '0;
        r = '0;
        d = 64'(den);
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return t_q60'(q);
    endfunction

    // atan(2^-i) in Q60 from its power series; atan(1) is pi/4
    function automatic t_q60 atan_f(input int i);
        t_q60 sum;
        t_q60 term;
        int   e;
        sum = '0;
        if (i == 0) begin
            sum = ATAN_ONE;
        end else begin
            for (int k = 0; k < 31; k++) begin
                e = i * (2 * k + 1);
                if (e <= 60) begin
                    term = udiv_f(64'sd1 <<< (60 - e), 2 * k + 1);
                    sum  = ((k & 1) != 0) ? sum - term : sum + term;
                end
            end
        end
        return sum;
    endfunction

    // inverse CORDIC gain for n steps, by Newton iteration on 1/sqrt(p)
    function automatic t_q60 gain_f(input int n);
        t_q60 p;
        t_q60 y;
        t_q60 t;
        p = ONE_Q;
        for (int i = 0; i < n; i++) begin
            p = p + (p >>> (2 * i));
        end
        y = GAIN_SEED;
        for (int i = 0; i < 8; i++) begin
            t = mulsh_f(mulsh_f(y, y, 60), p, 60);
            y = mulsh_f(y, 3 * ONE_Q - t, 61);
        end
        return y;
    endfunction

endpackage

/* hw/rtl/gcd_mul.sv */
// Four-stage signed 64x64 multiplier built from 32x32 partial products, shifted result.
module gcd_mul #(
    parameter int SHIFT = 60,
    parameter int TAG_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gcd_pkg::t_q60        i_a,
    input  gcd_pkg::t_q60        i_b,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output gcd_pkg::t_q60        o_p,
    output logic [TAG_W-1:0]     o_tag
);
    import gcd_pkg::*;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              r1_neg, r2_neg, r3_neg;
    logic [63:0]       r1_ua, r1_ub;
    logic [63:0]       r2_p00, r2_p01, r2_p10, r2_p11;
    logic [127:0]      r3_sum;
    logic [TAG_W-1:0]  r1_tag, r2_tag, r3_tag, r4_tag;
    t_q60              r4_p;
    logic [62:0]       w_mag;
    t_q60              n_p;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // shift and sign of the final stage
    always_comb begin
        w_mag = r3_sum[SHIFT +: 63];
        n_p   = r3_neg ? t_q60'(-{1'b0, w_mag}) : t_q60'({1'b0, w_mag});
    end

    // datapath: magnitude, partial products, sum, shift
    always_ff @(posedge i_clk) begin
        r1_neg <= i_a[63] ^ i_b[63];
        r1_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
        r1_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        r1_tag <= i_tag;

        r2_p00 <= {32'd0, r1_ua[31:0]}  * {32'd0, r1_ub[31:0]};
        r2_p01 <= {32'd0, r1_ua[31:0]}  * {32'd0, r1_ub[63:32]};
        r2_p10 <= {32'd0, r1_ua[63:32]} * {32'd0, r1_ub[31:0]};
        r2_p11 <= {32'd0, r1_ua[63:32]} * {32'd0, r1_ub[63:32]};
        r2_neg <= r1_neg;
        r2_tag <= r1_tag;

        r3_sum <= {64'd0, r2_p00} + {32'd0, r2_p01, 32'd0}
                + {32'd0, r2_p10, 32'd0} + {r2_p11, 64'd0};
        r3_neg <= r2_neg;
        r3_tag <= r2_tag;

        r4_p   <= n_p;
        r4_tag <= r3_tag;
    end

    assign o_valid = r_v4;
    assign o_p     = r4_p;
    assign o_tag   = r4_tag;

endmodule

/* hw/rtl/gcd_sincos.sv */
// Pipelined sine and cosine: turn reduction, quadrant fold, rotation CORDIC, residual fix.
module gcd_sincos #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gcd_pkg::t_turn  i_ang,
    output logic            o_valid,
    output gcd_pkg::t_q60   o_cos,
    output gcd_pkg::t_q60   o_sin
);
    import gcd_pkg::*;

    localparam int   N    = TRIG_ITERATIONS;
    localparam t_q60 GAIN = gain_f(TRIG_ITERATIONS);

    logic   r_v1, r_v2, r_v3;
    t_turn  r1_a, r2_a, r3_a;
    logic   r3_neg;

    logic   w_zv;
    t_q60   w_z;
    logic   w_zneg;

    logic   r_v [N];
    logic   r_ng [N];
    t_q60   r_x [N];
    t_q60   r_y [N];
    t_q60   r_z [N];

    logic          w_av, w_bv;
    t_q60          w_pa, w_pb;
    logic [64:0]   w_taga;
    logic [63:0]   w_tagb;
    t_q60          w_xc, w_yc;
    logic          r_out_v;
    t_q60          r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // remainder by a full turn, truncating toward zero
    always_ff @(posedge i_clk) begin
        if (i_ang >= FULL_TURN) begin
            r1_a <= i_ang - FULL_TURN;
        end else if (i_ang <= -FULL_TURN) begin
            r1_a <= i_ang + FULL_TURN;
        end else begin
            r1_a <= i_ang;
        end
    end

    // wrap into [-180, 180)
    always_ff @(posedge i_clk) begin
        if (r1_a >= HALF_TURN) begin
            r2_a <= r1_a - FULL_TURN;
        end else if (r1_a < -HALF_TURN) begin
            r2_a <= r1_a + FULL_TURN;
        end else begin
            r2_a <= r1_a;
        end
    end

    // fold into [-90, 90]; both results flip sign when folded
    always_ff @(posedge i_clk) begin
        if (r2_a > QUARTER_TURN) begin
            r3_a   <= r2_a - HALF_TURN;
            r3_neg <= 1'b1;
        end else if (r2_a < -QUARTER_TURN) begin
            r3_a   <= r2_a + HALF_TURN;
            r3_neg <= 1'b1;
        end else begin
            r3_a   <= r2_a;
            r3_neg <= 1'b0;
        end
    end

    // degrees to Q60 radians
    gcd_mul #(.SHIFT(23), .TAG_W(1)) u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_a     (t_q60'(r3_a)),
        .i_b     (DEG_Q),
        .i_tag   (r3_neg),
        .o_valid (w_zv),
        .o_p     (w_z),
        .o_tag   (w_zneg)
    );

    // rotation CORDIC, one step per stage
    for (genvar g = 0; g < N; g++) begin : g_rot
        localparam t_q60 ANG = atan_f(g);
        logic w_v, w_ng;
        t_q60 w_x, w_y, w_zi;
        if (g == 0) begin : g_first
            assign w_v  = w_zv;
            assign w_ng = w_zneg;
            assign w_x  = GAIN;
            assign w_y  = '0;
            assign w_zi = w_z;
        end else begin : g_next
            assign w_v  = r_v[g-1];
            assign w_ng = r_ng[g-1];
            assign w_x  = r_x[g-1];
            assign w_y  = r_y[g-1];
            assign w_zi = r_z[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ng[g] <= w_ng;
            if (!w_zi[63]) begin
                r_x[g] <= w_x - (w_y >>> g);
                r_y[g] <= w_y + (w_x >>> g);
                r_z[g] <= w_zi - ANG;
            end else begin
                r_x[g] <= w_x + (w_y >>> g);
                r_y[g] <= w_y - (w_x >>> g);
                r_z[g] <= w_zi + ANG;
            end
        end
    end

    // residual angle correction
    gcd_mul #(.SHIFT(60), .TAG_W(65)) u_fix_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[N-1]),
        .i_a     (r_y[N-1]),
        .i_b     (r_z[N-1]),
        .i_tag   ({r_ng[N-1], r_x[N-1]}),
        .o_valid (w_av),
        .o_p     (w_pa),
        .o_tag   (w_taga)
    );

    gcd_mul #(.SHIFT(60), .TAG_W(64)) u_fix_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[N-1]),
        .i_a     (r_x[N-1]),
        .i_b     (r_z[N-1]),
        .i_tag   (r_y[N-1]),
        .o_valid (w_bv),
        .o_p     (w_pb),
        .o_tag   (w_tagb)
    );

    assign w_xc = t_q60'(w_taga[63:0]) - w_pa;
    assign w_yc = t_q60'(w_tagb) + w_pb;

    // output register, sign restored after the fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_av & w_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= w_taga[64] ? -w_xc : w_xc;
        r_sin <= w_taga[64] ? -w_yc : w_yc;
    end

    assign o_valid = r_out_v;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

/* hw/rtl/gcd_acos.sv */
// Pipelined arccosine: clamp, 1-c^2, digit-by-digit square root, vectoring CORDIC.
module gcd_acos #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcd_pkg::t_q60  i_cos,
    output logic           o_valid,
    output gcd_pkg::t_q60  o_ang
);
    import gcd_pkg::*;

    localparam int   N    = TRIG_ITERATIONS;
    localparam int   S    = ISQRT_STEPS;
    localparam t_q60 GAIN = gain_f(TRIG_ITERATIONS);

    logic         r_v1, r_v2, r_v3;
    t_q60         r1_c, r2_c;
    logic         w_sq_v;
    t_q60         w_sq;
    logic [63:0]  w_sq_tag;
    t_q60         w_rem;
    logic [63:0]  r2_v;

    logic         r_qok [S];
    logic [63:0]  r_qv [S];
    logic [63:0]  r_qr [S];
    t_q60         r_qc [S];

    t_q60         r3_x, r3_y;
    logic         r3_neg;

    logic         r_v [N];
    logic         r_ng [N];
    t_q60         r_x [N];
    t_q60         r_y [N];
    t_q60         r_z [N];

    logic         w_fv;
    t_q60         w_fp;
    logic [64:0]  w_ftag;
    t_q60         w_z1, w_z2, n_ang;
    logic         r_out_v;
    t_q60         r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= w_sq_v;
            r_v3 <= r_qok[S-1];
        end
    end

    // clamp to [-1, 1]
    always_ff @(posedge i_clk) begin
        if (i_cos > ONE_Q) begin
            r1_c <= ONE_Q;
        end else if (i_cos < -ONE_Q) begin
            r1_c <= -ONE_Q;
        end else begin
            r1_c <= i_cos;
        end
    end

    gcd_mul #(.SHIFT(60), .TAG_W(64)) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_a     (r1_c),
        .i_b     (r1_c),
        .i_tag   (r1_c),
        .o_valid (w_sq_v),
        .o_p     (w_sq),
        .o_tag   (w_sq_tag)
    );

    // 1 - c^2, floored at zero
    assign w_rem = ONE_Q - w_sq;

    always_ff @(posedge i_clk) begin
        r2_v <= w_rem[63] ? 64'd0 : 64'(w_rem);
        r2_c <= t_q60'(w_sq_tag);
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < S; s++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (60 - 2 * s);
        logic        w_ok;
        logic [63:0] w_v, w_r, w_t;
        t_q60        w_c;
        if (s == 0) begin : g_first
            assign w_ok = r_v2;
            assign w_v  = r2_v;
            assign w_r  = '0;
            assign w_c  = r2_c;
        end else begin : g_next
            assign w_ok = r_qok[s-1];
            assign w_v  = r_qv[s-1];
            assign w_r  = r_qr[s-1];
            assign w_c  = r_qc[s-1];
        end
        assign w_t = w_r + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qok[s] <= 1'b0;
            end else begin
                r_qok[s] <= w_ok;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qc[s] <= w_c;
            if (w_v >= w_t) begin
                r_qv[s] <= w_v - w_t;
                r_qr[s] <= (w_r >> 1) + BIT;
            end else begin
                r_qv[s] <= w_v;
                r_qr[s] <= w_r >> 1;
            end
        end
    end

    // start vector (|c|, sqrt(1-c^2))
    always_ff @(posedge i_clk) begin
        r3_neg <= r_qc[S-1][63];
        r3_x   <= r_qc[S-1][63] ? -r_qc[S-1] : r_qc[S-1];
        r3_y   <= t_q60'(r_qr[S-1] << 30);
    end

    // vectoring CORDIC, one step per stage
    for (genvar g = 0; g < N; g++) begin : g_vec
        localparam t_q60 ANG = atan_f(g);
        logic w_v, w_ng;
        t_q60 w_x, w_y, w_zi;
        if (g == 0) begin : g_first
            assign w_v  = r_v3;
            assign w_ng = r3_neg;
            assign w_x  = r3_x;
            assign w_y  = r3_y;
            assign w_zi = '0;
        end else begin : g_next
            assign w_v  = r_v[g-1];
            assign w_ng = r_ng[g-1];
            assign w_x  = r_x[g-1];
            assign w_y  = r_y[g-1];
            assign w_zi = r_z[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ng[g] <= w_ng;
            if (!w_y[63]) begin
                r_x[g] <= w_x + (w_y >>> g);
                r_y[g] <= w_y - (w_x >>> g);
                r_z[g] <= w_zi + ANG;
            end else begin
                r_x[g] <= w_x - (w_y >>> g);
                r_y[g] <= w_y + (w_x >>> g);
                r_z[g] <= w_zi - ANG;
            end
        end
    end

    // leftover y turned into angle
    gcd_mul #(.SHIFT(60), .TAG_W(65)) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[N-1]),
        .i_a     (r_y[N-1]),
        .i_b     (GAIN),
        .i_tag   ({r_ng[N-1], r_z[N-1]}),
        .o_valid (w_fv),
        .o_p     (w_fp),
        .o_tag   (w_ftag)
    );

    // mirror for negative cosine, clamp to [0, pi]
    always_comb begin
        w_z1 = t_q60'(w_ftag[63:0]) + w_fp;
        w_z2 = w_ftag[64] ? PI_Q - w_z1 : w_z1;
        if (w_z2[63]) begin
            n_ang = '0;
        end else if (w_z2 > PI_Q) begin
            n_ang = PI_Q;
        end else begin
            n_ang = w_z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang;
    end

    assign o_valid = r_out_v;
    assign o_ang   = r_ang;

endmodule

/* hw/rtl/great_circle_distance_core.sv */
// Great-circle distance core: point pair in, distance in metres out, fully pipelined.
// The delay from start to o_strobe is set by the two CORDIC chains, the 31-stage square root
// and the multipliers.
// Throughput: one word per cycle; busy is always low and results cannot be stalled.
// Reset (synchronous, active low) clears all valid bits and loads radius 6378137 m.
module great_circle_distance_core #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [30:0]  i_first_latitude,
    input  logic signed [31:0]  i_first_longitude,
    input  logic signed [30:0]  i_second_latitude,
    input  logic signed [31:0]  i_second_longitude,
    output logic                o_strobe,
    output logic [25:0]         o_distance_m,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gcd_pkg::*;

    logic         w_radius_wr;
    logic [23:0]  r_radius;

    logic         r_in_v;
    t_turn        r_lat1, r_lat2, r_dlon;

    logic         w_sc_v;
    t_q60         w_c1, w_s1, w_c2, w_s2, w_cd, w_sd;

    logic         w_ma_v;
    t_q60         w_ma, w_mb;
    logic [63:0]  w_ma_tag;
    logic         w_mc_v;
    t_q60         w_mc;
    logic [63:0]  w_mc_tag;

    logic         r_cosd_v;
    t_q60         r_cosd;

    logic         w_ang_v;
    t_q60         w_ang;
    logic         w_half_v;
    t_q60         w_half;
    logic [63:0]  w_half1;

    logic         r_strobe;
    logic [25:0]  r_dist;

    // configuration port
    assign pready      = 1'b1;
    assign w_radius_wr = psel & penable & pwrite & (paddr == REG_RADIUS_ADDR);
    assign prdata      = (paddr == REG_RADIUS_ADDR) ? {8'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (w_radius_wr) begin
            r_radius <= pwdata[23:0];
        end
    end

    // input word register, longitude difference
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat1 <= t_turn'(i_first_latitude);
        r_lat2 <= t_turn'(i_second_latitude);
        r_dlon <= t_turn'(i_second_longitude) - t_turn'(i_first_longitude);
    end

    // three trig units in lockstep
    gcd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_ang   (r_lat1),
        .o_valid (w_sc_v),
        .o_cos   (w_c1),
        .o_sin   (w_s1)
    );

    gcd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_ang   (r_lat2),
        .o_valid (),
        .o_cos   (w_c2),
        .o_sin   (w_s2)
    );

    gcd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_ang   (r_dlon),
        .o_valid (),
        .o_cos   (w_cd),
        .o_sin   (w_sd)
    );

    // cosd = c1*c2*cd + s1*s2
    gcd_mul #(.SHIFT(60), .TAG_W(64)) u_mul_cc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_v),
        .i_a     (w_c1),
        .i_b     (w_c2),
        .i_tag   (w_cd),
        .o_valid (w_ma_v),
        .o_p     (w_ma),
        .o_tag   (w_ma_tag)
    );

    gcd_mul #(.SHIFT(60), .TAG_W(1)) u_mul_ss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_v),
        .i_a     (w_s1),
        .i_b     (w_s2),
        .i_tag   (w_sd[63]),
        .o_valid (),
        .o_p     (w_mb),
        .o_tag   ()
    );

    gcd_mul #(.SHIFT(60), .TAG_W(64)) u_mul_ccd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ma_v),
        .i_a     (w_ma),
        .i_b     (t_q60'(w_ma_tag)),
        .i_tag   (w_mb),
        .o_valid (w_mc_v),
        .o_p     (w_mc),
        .o_tag   (w_mc_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cosd_v <= 1'b0;
        end else begin
            r_cosd_v <= w_mc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cosd <= w_mc + t_q60'(w_mc_tag);
    end

    // central angle
    gcd_acos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_acos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cosd_v),
        .i_cos   (r_cosd),
        .o_valid (w_ang_v),
        .o_ang   (w_ang)
    );

    // scale by radius, twice the distance
    gcd_mul #(.SHIFT(59), .TAG_W(1)) u_mul_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ang_v),
        .i_a     (w_ang),
        .i_b     (t_q60'({40'd0, r_radius})),
        .i_tag   (1'b0),
        .o_valid (w_half_v),
        .o_p     (w_half),
        .o_tag   ()
    );

    // round half up and drive the result word
    assign w_half1 = 64'(w_half) + 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_half_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= w_half1[26:1];
    end

    assign o_strobe     = r_strobe;
    assign o_distance_m = r_dist;

endmodule
